### design/ilc_pkg.sv
package ilc_pkg;

  typedef enum logic [2:0] {
    LT_BLANK     = 3'd0,
    LT_COMMENT   = 3'd1,
    LT_SECTION   = 3'd2,
    LT_KEY_VALUE = 3'd3,
    LT_MALFORMED = 3'd4
  } line_type_t;

  typedef enum logic [1:0] {
    ES_LF   = 2'd0,
    ES_CR   = 2'd1,
    ES_CRLF = 2'd2
  } ending_style_t;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOT  = 1'b1;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

### design/ilc_queue.sv
module ilc_queue #(
  parameter type item_t = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/ilc_front.sv
module ilc_front #(
  parameter type rec_t = logic,
  parameter int unsigned MAX_LINE_LEN = 4096,
  parameter int unsigned COL_W = 13,
  parameter int unsigned LN_W = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_char_code,
  output logic       rec_push,
  output rec_t       rec_data,
  input  logic       rec_full
);

  localparam logic [COL_W-1:0] MAX_COL = COL_W'(MAX_LINE_LEN);
  localparam logic [LN_W-1:0]  LN_MAX  = {LN_W{1'b1}};

  logic [COL_W-1:0] column_r, column_nxt;
  logic             first_valid_r, first_valid_nxt;
  logic [7:0]       first_char_r, first_char_nxt;
  logic [COL_W-1:0] first_pos_r, first_pos_nxt;
  logic             second_valid_r, second_valid_nxt;
  logic [COL_W-1:0] second_pos_r, second_pos_nxt;
  logic [7:0]       last_char_r, last_char_nxt;
  logic [COL_W-1:0] last_pos_r, last_pos_nxt;
  logic [COL_W-1:0] prior_pos_r, prior_pos_nxt;
  logic             eq_valid_r, eq_valid_nxt;
  logic [COL_W-1:0] eq_pos_r, eq_pos_nxt;
  logic             key_valid_r, key_valid_nxt;
  logic [COL_W-1:0] key_first_r, key_first_nxt;
  logic [COL_W-1:0] key_last_r, key_last_nxt;
  logic             overflow_r, overflow_nxt;
  logic [LN_W-1:0]  line_count_r, line_count_nxt;
  logic             prev_cr_r, prev_cr_nxt;
  logic             saw_crlf_r, saw_crlf_nxt;
  logic             saw_lone_cr_r, saw_lone_cr_nxt;

  logic in_fire, is_eot, end_line, ch_ws;
  ilc_pkg::ending_style_t style;

  assign in_ready = !rec_full;
  assign in_fire  = in_valid && in_ready;
  assign is_eot   = (in_cmd == ilc_pkg::CMD_EOT);
  assign ch_ws    = ilc_pkg::is_ws(in_char_code);

  always_comb begin
    if (!is_eot) begin
      style = ilc_pkg::ES_LF;
    end else if (saw_crlf_r) begin
      style = ilc_pkg::ES_CRLF;
    end else if (saw_lone_cr_r || prev_cr_r) begin
      style = ilc_pkg::ES_CR;
    end else begin
      style = ilc_pkg::ES_LF;
    end
  end

  always_comb begin
    rec_data              = '0;
    rec_data.ln           = line_count_r;
    rec_data.first_valid  = first_valid_r;
    rec_data.first_char   = first_char_r;
    rec_data.first_pos    = first_pos_r;
    rec_data.second_valid = second_valid_r;
    rec_data.second_pos   = second_pos_r;
    rec_data.last_char    = last_char_r;
    rec_data.last_pos     = last_pos_r;
    rec_data.prior_pos    = prior_pos_r;
    rec_data.eq_valid     = eq_valid_r;
    rec_data.eq_pos       = eq_pos_r;
    rec_data.key_valid    = key_valid_r;
    rec_data.key_first    = key_first_r;
    rec_data.key_last     = key_last_r;
    rec_data.column       = column_r;
    rec_data.overflow     = overflow_r;
    rec_data.is_last      = is_eot;
    rec_data.style        = style;
  end

  always_comb begin
    column_nxt       = column_r;
    first_valid_nxt  = first_valid_r;
    first_char_nxt   = first_char_r;
    first_pos_nxt    = first_pos_r;
    second_valid_nxt = second_valid_r;
    second_pos_nxt   = second_pos_r;
    last_char_nxt    = last_char_r;
    last_pos_nxt     = last_pos_r;
    prior_pos_nxt    = prior_pos_r;
    eq_valid_nxt     = eq_valid_r;
    eq_pos_nxt       = eq_pos_r;
    key_valid_nxt    = key_valid_r;
    key_first_nxt    = key_first_r;
    key_last_nxt     = key_last_r;
    overflow_nxt     = overflow_r;
    line_count_nxt   = line_count_r;
    prev_cr_nxt      = prev_cr_r;
    saw_crlf_nxt     = saw_crlf_r;
    saw_lone_cr_nxt  = saw_lone_cr_r;
    rec_push         = 1'b0;
    end_line         = 1'b0;

    if (in_fire) begin
      if (is_eot) begin
        rec_push        = 1'b1;
        end_line        = 1'b1;
        line_count_nxt  = LN_W'(1);
        prev_cr_nxt     = 1'b0;
        saw_crlf_nxt    = 1'b0;
        saw_lone_cr_nxt = 1'b0;
      end else begin
        if (prev_cr_r && (in_char_code != ilc_pkg::CH_LF)) begin
          saw_lone_cr_nxt = 1'b1;
        end
        if (in_char_code == ilc_pkg::CH_LF) begin
          if (prev_cr_r) begin
            prev_cr_nxt  = 1'b0;
            saw_crlf_nxt = 1'b1;
          end else begin
            rec_push = 1'b1;
            end_line = 1'b1;
          end
        end else if (in_char_code == ilc_pkg::CH_CR) begin
          prev_cr_nxt = 1'b1;
          rec_push    = 1'b1;
          end_line    = 1'b1;
        end else begin
          prev_cr_nxt = 1'b0;
          if (column_r >= MAX_COL) begin
            overflow_nxt = 1'b1;
          end else begin
            if ((in_char_code == ilc_pkg::CH_EQUALS) && !eq_valid_r) begin
              eq_valid_nxt = 1'b1;
              eq_pos_nxt   = column_r;
            end else if (!eq_valid_r && !ch_ws) begin
              if (!key_valid_r) begin
                key_valid_nxt = 1'b1;
                key_first_nxt = column_r;
              end
              key_last_nxt = column_r;
            end
            if (!ch_ws) begin
              if (!first_valid_r) begin
                first_valid_nxt = 1'b1;
                first_pos_nxt   = column_r;
                first_char_nxt  = in_char_code;
              end else begin
                if (!second_valid_r) begin
                  second_valid_nxt = 1'b1;
                  second_pos_nxt   = column_r;
                end
                prior_pos_nxt = last_pos_r;
              end
              last_pos_nxt  = column_r;
              last_char_nxt = in_char_code;
            end
            column_nxt = column_r + COL_W'(1);
          end
        end
        if (end_line && (line_count_r != LN_MAX)) begin
          line_count_nxt = line_count_r + LN_W'(1);
        end
      end

      if (end_line) begin
        column_nxt       = '0;
        first_valid_nxt  = 1'b0;
        first_char_nxt   = '0;
        first_pos_nxt    = '0;
        second_valid_nxt = 1'b0;
        second_pos_nxt   = '0;
        last_char_nxt    = '0;
        last_pos_nxt     = '0;
        prior_pos_nxt    = '0;
        eq_valid_nxt     = 1'b0;
        eq_pos_nxt       = '0;
        key_valid_nxt    = 1'b0;
        key_first_nxt    = '0;
        key_last_nxt     = '0;
        overflow_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r       <= '0;
      first_valid_r  <= 1'b0;
      first_char_r   <= '0;
      first_pos_r    <= '0;
      second_valid_r <= 1'b0;
      second_pos_r   <= '0;
      last_char_r    <= '0;
      last_pos_r     <= '0;
      prior_pos_r    <= '0;
      eq_valid_r     <= 1'b0;
      eq_pos_r       <= '0;
      key_valid_r    <= 1'b0;
      key_first_r    <= '0;
      key_last_r     <= '0;
      overflow_r     <= 1'b0;
      line_count_r   <= LN_W'(1);
      prev_cr_r      <= 1'b0;
      saw_crlf_r     <= 1'b0;
      saw_lone_cr_r  <= 1'b0;
    end else begin
      column_r       <= column_nxt;
      first_valid_r  <= first_valid_nxt;
      first_char_r   <= first_char_nxt;
      first_pos_r    <= first_pos_nxt;
      second_valid_r <= second_valid_nxt;
      second_pos_r   <= second_pos_nxt;
      last_char_r    <= last_char_nxt;
      last_pos_r     <= last_pos_nxt;
      prior_pos_r    <= prior_pos_nxt;
      eq_valid_r     <= eq_valid_nxt;
      eq_pos_r       <= eq_pos_nxt;
      key_valid_r    <= key_valid_nxt;
      key_first_r    <= key_first_nxt;
      key_last_r     <= key_last_nxt;
      overflow_r     <= overflow_nxt;
      line_count_r   <= line_count_nxt;
      prev_cr_r      <= prev_cr_nxt;
      saw_crlf_r     <= saw_crlf_nxt;
      saw_lone_cr_r  <= saw_lone_cr_nxt;
    end
  end

endmodule

### design/ilc_back.sv
module ilc_back #(
  parameter type rec_t = logic,
  parameter int unsigned COL_W = 13,
  parameter int unsigned LN_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rec_valid,
  input  rec_t             rec_data,
  output logic             rec_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [LN_W-1:0]  out_line_number,
  output logic [2:0]       out_line_type,
  output logic [COL_W-1:0] out_name_start,
  output logic [COL_W-1:0] out_name_end,
  output logic [COL_W-1:0] out_value_start,
  output logic [COL_W-1:0] out_line_length,
  output logic [LN_W-1:0]  out_section_line,
  output logic [1:0]       out_ending_style,
  output logic             out_is_last,
  output logic             out_too_long
);

  logic                valid_r, valid_nxt;
  logic [LN_W-1:0]     section_r, section_nxt;
  logic [LN_W-1:0]     line_number_r;
  ilc_pkg::line_type_t line_type_r, line_type;
  logic [COL_W-1:0]    name_start_r, name_start;
  logic [COL_W-1:0]    name_end_r, name_end;
  logic [COL_W-1:0]    value_start_r, value_start;
  logic [COL_W-1:0]    line_length_r;
  logic [LN_W-1:0]     section_line_r, section_line;
  logic [1:0]          ending_style_r;
  logic                is_last_r;
  logic                too_long_r;
  logic [COL_W-1:0]    span;

  assign rec_pop = rec_valid && (!valid_r || out_ready);
  assign span    = rec_data.last_pos - rec_data.first_pos;

  always_comb begin
    line_type    = ilc_pkg::LT_MALFORMED;
    name_start   = '0;
    name_end     = '0;
    value_start  = '0;
    section_line = section_r;
    if (!rec_data.first_valid) begin
      line_type = ilc_pkg::LT_BLANK;
    end else if ((rec_data.first_char == ilc_pkg::CH_SEMI) ||
                 (rec_data.first_char == ilc_pkg::CH_HASH)) begin
      line_type = ilc_pkg::LT_COMMENT;
    end else if ((rec_data.first_char == ilc_pkg::CH_LBRACK) &&
                 (rec_data.last_char == ilc_pkg::CH_RBRACK) &&
                 (span >= COL_W'(2))) begin
      line_type    = ilc_pkg::LT_SECTION;
      section_line = rec_data.ln;
      if (rec_data.second_valid && (rec_data.second_pos < rec_data.last_pos)) begin
        name_start = rec_data.second_pos;
        name_end   = rec_data.prior_pos + COL_W'(1);
      end else begin
        name_start = rec_data.first_pos + COL_W'(1);
        name_end   = rec_data.first_pos + COL_W'(1);
      end
    end else if (rec_data.eq_valid && (rec_data.eq_pos != '0)) begin
      line_type = ilc_pkg::LT_KEY_VALUE;
      if (rec_data.key_valid) begin
        name_start = rec_data.key_first;
        name_end   = rec_data.key_last + COL_W'(1);
      end else begin
        name_start = rec_data.eq_pos;
        name_end   = rec_data.eq_pos;
      end
      value_start = rec_data.eq_pos + COL_W'(1);
    end
  end

  always_comb begin
    valid_nxt   = valid_r;
    section_nxt = section_r;
    if (rec_pop) begin
      valid_nxt   = 1'b1;
      section_nxt = rec_data.is_last ? '0 : section_line;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      section_r <= '0;
    end else begin
      valid_r   <= valid_nxt;
      section_r <= section_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      line_number_r  <= rec_data.ln;
      line_type_r    <= line_type;
      name_start_r   <= name_start;
      name_end_r     <= name_end;
      value_start_r  <= value_start;
      line_length_r  <= rec_data.column;
      section_line_r <= section_line;
      ending_style_r <= rec_data.style;
      is_last_r      <= rec_data.is_last;
      too_long_r     <= rec_data.overflow;
    end
  end

  assign out_valid        = valid_r;
  assign out_line_number  = line_number_r;
  assign out_line_type    = line_type_r;
  assign out_name_start   = name_start_r;
  assign out_name_end     = name_end_r;
  assign out_value_start  = value_start_r;
  assign out_line_length  = line_length_r;
  assign out_section_line = section_line_r;
  assign out_ending_style = ending_style_r;
  assign out_is_last      = is_last_r;
  assign out_too_long     = too_long_r;

endmodule

### design/ini_line_classifier.sv
// Streaming INI line classifier. Takes one character (or an end-of-text
// command) per transaction and returns one transaction per line with its
// class, trimmed name span, value start, length and section context. A
// character is accepted every cycle while the two-entry line queue between
// the character scanner and the line classifier has room; a line result
// goes through that queue into the output register, and results drain at
// one per cycle while out_ready is high. The end-of-text command also
// returns the whole block to its reset state for the next text.
module ini_line_classifier #(
  parameter int unsigned MAX_LINE_LEN     = 4096,
  parameter int unsigned LINE_NUMBER_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic [7:0]                           in_char_code,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [LINE_NUMBER_BITS-1:0]          out_line_number,
  output logic [2:0]                           out_line_type,
  output logic [$clog2(MAX_LINE_LEN+1)-1:0]    out_name_start,
  output logic [$clog2(MAX_LINE_LEN+1)-1:0]    out_name_end,
  output logic [$clog2(MAX_LINE_LEN+1)-1:0]    out_value_start,
  output logic [$clog2(MAX_LINE_LEN+1)-1:0]    out_line_length,
  output logic [LINE_NUMBER_BITS-1:0]          out_section_line,
  output logic [1:0]                           out_ending_style,
  output logic                                 out_is_last,
  output logic                                 out_too_long
);

  localparam int unsigned COL_W = $clog2(MAX_LINE_LEN + 1);
  localparam int unsigned LN_W  = LINE_NUMBER_BITS;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [LN_W-1:0]        ln;
    logic                   first_valid;
    logic [7:0]             first_char;
    logic [COL_W-1:0]       first_pos;
    logic                   second_valid;
    logic [COL_W-1:0]       second_pos;
    logic [7:0]             last_char;
    logic [COL_W-1:0]       last_pos;
    logic [COL_W-1:0]       prior_pos;
    logic                   eq_valid;
    logic [COL_W-1:0]       eq_pos;
    logic                   key_valid;
    logic [COL_W-1:0]       key_first;
    logic [COL_W-1:0]       key_last;
    logic [COL_W-1:0]       column;
    logic                   overflow;
    logic                   is_last;
    ilc_pkg::ending_style_t style;
  } line_rec_t;

  line_rec_t push_data, pop_data;
  logic      push, full, pop, not_empty;

  ilc_front #(
    .rec_t        (line_rec_t),
    .MAX_LINE_LEN (MAX_LINE_LEN),
    .COL_W        (COL_W),
    .LN_W         (LN_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_char_code (in_char_code),
    .rec_push     (push),
    .rec_data     (push_data),
    .rec_full     (full)
  );

  ilc_queue #(
    .item_t (line_rec_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  ilc_back #(
    .rec_t (line_rec_t),
    .COL_W (COL_W),
    .LN_W  (LN_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rec_valid        (not_empty),
    .rec_data         (pop_data),
    .rec_pop          (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_number  (out_line_number),
    .out_line_type    (out_line_type),
    .out_name_start   (out_name_start),
    .out_name_end     (out_name_end),
    .out_value_start  (out_value_start),
    .out_line_length  (out_line_length),
    .out_section_line (out_section_line),
    .out_ending_style (out_ending_style),
    .out_is_last      (out_is_last),
    .out_too_long     (out_too_long)
  );

endmodule
